>>> rtl/core/random_tour_search_best_keeper_macros.svh
// Assertion macros for the random tour search core.
// Uses clk and rst_n of the module that expands them; no other dependencies.
`ifndef RANDOM_TOUR_SEARCH_BEST_KEEPER_MACROS_SVH
`define RANDOM_TOUR_SEARCH_BEST_KEEPER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define RTSBK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define RTSBK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rtsbk_pkg.sv
// Package for the random tour search core: sizes, op and status codes.
// No dependencies.
`default_nettype none

package rtsbk_pkg;

  // Built sizes
  localparam int MAX_CITIES = 32;
  localparam int COST_BITS  = 16;
  localparam int PATH_SLOTS = MAX_CITIES + 1;

  // Field widths fixed by the interface
  localparam int CITY_W  = 5;
  localparam int NUM_W   = 6;
  localparam int COST_W  = 22;
  localparam int EDGE_W  = 16;

  // Derived storage widths
  localparam int LEN_W   = $clog2(PATH_SLOTS + 1);
  localparam int MAT_AW  = $clog2(MAX_CITIES * MAX_CITIES);
  localparam int PATH_AW = $clog2(2 * PATH_SLOTS);

  localparam logic [COST_W-1:0] COST_MAX = '1;

  // Input op codes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_PROPOSE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // Register index (from paddr[2])
  localparam logic REG_NUM_CITIES = 1'b0;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_REJECTED   = 3'd1,
    ST_NEW_BEST   = 3'd2,
    ST_NOT_BETTER = 3'd3,
    ST_PATH_ENTRY = 3'd4,
    ST_NO_TOUR    = 3'd5
  } status_t;

endpackage

`default_nettype wire

>>> rtl/core/random_tour_search_best_keeper.sv
// Random tour search: cost matrix RAM, double-buffered path RAM, best-tour keeper.
// Depends on rtsbk_pkg and random_tour_search_best_keeper_macros.svh.
//
// Builds tours from city 0 over a cost matrix held in a 1024 x 16 synchronous RAM.
// A matrix write (op 0) is taken in idle and gives no result. A proposal (op 1)
// does the matrix read for the edge from the current city, then, once the output
// register is free, the visited check, saturating add and path RAM write. Once
// every city in use is visited, the next proposal closes the tour to city 0; the
// tour becomes the best when it is the first or strictly cheaper, which swaps the
// two halves of the path RAM. A readout (op 2) passes S_EXEC, then alternates
// S_RD_ADDR and S_RD_OUT for each path entry, as the path RAM read is registered.
// The path RAM and matrix come up undefined; no clearing pass runs after reset.
`default_nettype none

module random_tour_search_best_keeper
  import rtsbk_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // from_city[4:0], to_city[9:5], edge_cost[25:10]
  input  wire logic [1:0]  in_tuser,    // op[1:0]
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // city[4:0], cost[26:5]
  output logic [2:0]       out_tuser,   // status[2:0]
  output logic             out_tlast,
  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RD_ADDR,
    S_RD_OUT
  } state_t;

  // Input fields
  logic [1:0]        in_op;
  logic [CITY_W-1:0] in_from;
  logic [CITY_W-1:0] in_to;
  logic [EDGE_W-1:0] in_edge;

  assign in_op   = in_tuser;
  assign in_from = in_tdata[CITY_W-1:0];
  assign in_to   = in_tdata[2*CITY_W-1:CITY_W];
  assign in_edge = in_tdata[2*CITY_W+EDGE_W-1:2*CITY_W];

  // Control and tour state
  state_t                state_r, state_nxt;
  logic [1:0]            op_r, op_nxt;
  logic [CITY_W-1:0]     to_r, to_nxt;
  logic [CITY_W-1:0]     cur_r, cur_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [COST_W-1:0]     run_r, run_nxt;
  logic [COST_W-1:0]     best_cost_r, best_cost_nxt;
  logic                  best_valid_r, best_valid_nxt;
  logic [LEN_W-1:0]      best_len_r, best_len_nxt;
  logic                  wsel_r, wsel_nxt;
  logic [MAX_CITIES-1:0] visited_r, visited_nxt;
  logic [LEN_W-1:0]      idx_r, idx_nxt;
  logic [NUM_W-1:0]      num_cities_r, num_cities_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [CITY_W-1:0]     out_city_r, out_city_nxt;
  logic [COST_W-1:0]     out_cost_r, out_cost_nxt;
  logic                  out_last_r, out_last_nxt;

  logic in_accept;
  logic out_free;
  logic cfg_write;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_write = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Effective city count, clamped to the built range
  logic [NUM_W-1:0] n_cities;

  always_comb begin
    if (num_cities_r < NUM_W'(2)) begin
      n_cities = NUM_W'(2);
    end else if (num_cities_r > NUM_W'(MAX_CITIES)) begin
      n_cities = NUM_W'(MAX_CITIES);
    end else begin
      n_cities = num_cities_r;
    end
  end

  logic tour_full;
  assign tour_full = (LEN_W'(len_r) >= LEN_W'(n_cities));

  // Cost matrix RAM
  logic [COST_BITS-1:0] mat_mem [MAX_CITIES*MAX_CITIES];
  logic [COST_BITS-1:0] mat_q;
  logic                 mat_we;
  logic                 mat_re;
  logic [MAT_AW-1:0]    mat_waddr;
  logic [MAT_AW-1:0]    mat_raddr;
  logic [CITY_W-1:0]    mat_rcol;

  assign mat_we = in_accept && (in_op == OP_WRITE) &&
                  (32'(in_from) < MAX_CITIES) && (32'(in_to) < MAX_CITIES);
  assign mat_re = in_accept && (in_op == OP_PROPOSE);
  assign mat_waddr = MAT_AW'(MAT_AW'(in_from) * MAT_AW'(MAX_CITIES) + MAT_AW'(in_to));
  assign mat_rcol  = tour_full ? '0 : in_to;
  assign mat_raddr = MAT_AW'(MAT_AW'(cur_r) * MAT_AW'(MAX_CITIES) + MAT_AW'(mat_rcol));

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= in_edge[COST_BITS-1:0];
    end
    if (mat_re) begin
      mat_q <= mat_mem[mat_raddr];
    end
  end

  // Path RAM: two halves, working half selected by wsel_r.
  // Entry 0 and the closing entry are always city 0 and are not stored.
  logic [CITY_W-1:0]  path_mem [2*PATH_SLOTS];
  logic [CITY_W-1:0]  path_q;
  logic               path_we;
  logic [PATH_AW-1:0] path_waddr;
  logic [PATH_AW-1:0] path_raddr;

  assign path_waddr = wsel_r ? PATH_AW'(PATH_AW'(PATH_SLOTS) + PATH_AW'(len_r))
                             : PATH_AW'(len_r);
  assign path_raddr = wsel_r ? PATH_AW'(idx_r)
                             : PATH_AW'(PATH_AW'(PATH_SLOTS) + PATH_AW'(idx_r));

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[path_waddr] <= to_r;
    end
    if (state_r == S_RD_ADDR) begin
      path_q <= path_mem[path_raddr];
    end
  end

  // Saturating edge add
  logic [COST_W:0]   sum_raw;
  logic [COST_W-1:0] sum_sat;

  assign sum_raw = {1'b0, run_r} + (COST_W+1)'(mat_q);
  assign sum_sat = sum_raw[COST_W] ? COST_MAX : sum_raw[COST_W-1:0];

  logic keep;
  assign keep = !best_valid_r || (sum_sat < best_cost_r);

  logic rd_last;
  assign rd_last = (idx_r == LEN_W'(best_len_r - LEN_W'(1)));

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    to_nxt         = to_r;
    cur_nxt        = cur_r;
    len_nxt        = len_r;
    run_nxt        = run_r;
    best_cost_nxt  = best_cost_r;
    best_valid_nxt = best_valid_r;
    best_len_nxt   = best_len_r;
    wsel_nxt       = wsel_r;
    visited_nxt    = visited_r;
    idx_nxt        = idx_r;
    num_cities_nxt = num_cities_r;
    out_status_nxt = out_status_r;
    out_city_nxt   = out_city_r;
    out_cost_nxt   = out_cost_r;
    out_last_nxt   = out_last_r;
    path_we        = 1'b0;

    // Drop the result once transferred
    out_valid_nxt = out_valid_r && !out_tready;

    // Register write
    if (cfg_write && (cfg_paddr[2] == REG_NUM_CITIES)) begin
      num_cities_nxt = cfg_pwdata[NUM_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept && ((in_op == OP_PROPOSE) || (in_op == OP_READ))) begin
          op_nxt    = in_op;
          to_nxt    = in_to;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          case (op_r)
            OP_PROPOSE: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (tour_full) begin
                // Close the tour, keep it if better, restart
                out_status_nxt = keep ? ST_NEW_BEST : ST_NOT_BETTER;
                out_city_nxt   = '0;
                out_cost_nxt   = sum_sat;
                if (keep) begin
                  best_cost_nxt  = sum_sat;
                  best_valid_nxt = 1'b1;
                  best_len_nxt   = (32'(len_r) < PATH_SLOTS) ? LEN_W'(len_r + LEN_W'(1))
                                                             : LEN_W'(PATH_SLOTS);
                  wsel_nxt       = !wsel_r;
                end
                visited_nxt = MAX_CITIES'(1);
                cur_nxt     = '0;
                len_nxt     = LEN_W'(1);
                run_nxt     = '0;
              end else if ((NUM_W'(to_r) >= n_cities) || visited_r[to_r]) begin
                out_status_nxt = ST_REJECTED;
                out_city_nxt   = to_r;
                out_cost_nxt   = run_r;
              end else begin
                // Append the city
                path_we             = 1'b1;
                run_nxt             = sum_sat;
                visited_nxt[to_r]   = 1'b1;
                len_nxt             = LEN_W'(len_r + LEN_W'(1));
                cur_nxt             = to_r;
                out_status_nxt      = ST_ACCEPTED;
                out_city_nxt        = to_r;
                out_cost_nxt        = sum_sat;
              end
            end
            OP_READ: begin
              if (!best_valid_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_NO_TOUR;
                out_city_nxt   = '0;
                out_cost_nxt   = '0;
                out_last_nxt   = 1'b1;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_RD_ADDR;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_RD_ADDR: begin
        state_nxt = S_RD_OUT;
      end

      S_RD_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_PATH_ENTRY;
          out_city_nxt   = ((idx_r == '0) || rd_last) ? '0 : path_q;
          out_cost_nxt   = best_cost_r;
          out_last_nxt   = rd_last;
          if (rd_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = LEN_W'(idx_r + LEN_W'(1));
            state_nxt = S_RD_ADDR;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_r        <= '0;
      len_r        <= LEN_W'(1);
      run_r        <= '0;
      best_cost_r  <= '0;
      best_valid_r <= 1'b0;
      best_len_r   <= '0;
      wsel_r       <= 1'b0;
      visited_r    <= MAX_CITIES'(1);
      num_cities_r <= NUM_W'(MAX_CITIES);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_r        <= cur_nxt;
      len_r        <= len_nxt;
      run_r        <= run_nxt;
      best_cost_r  <= best_cost_nxt;
      best_valid_r <= best_valid_nxt;
      best_len_r   <= best_len_nxt;
      wsel_r       <= wsel_nxt;
      visited_r    <= visited_nxt;
      num_cities_r <= num_cities_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    to_r         <= to_nxt;
    idx_r        <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_city_r   <= out_city_nxt;
    out_cost_r   <= out_cost_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Ports
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = 32'({out_cost_r, out_city_r});

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_NUM_CITIES) ? 32'(num_cities_r) : '0;

  // Checks
  `include "random_tour_search_best_keeper_macros.svh"

  `RTSBK_ASSERT_IMP(a_start_marked, 1'b1, visited_r[0], "city 0 lost its visited mark")
  `RTSBK_ASSERT_IMP(a_marks_match_len, 1'b1, $countones(visited_r) == 32'(len_r),
                    "visited marks disagree with path length")
  `RTSBK_ASSERT_IMP(a_best_kept, out_valid_r && (out_status_r == ST_NEW_BEST),
                    best_valid_r && (best_cost_r == out_cost_r),
                    "new best reported but not kept")

endmodule

`default_nettype wire

>>> sim/random_tour_search_best_keeper_test.sv
`timescale 1ns / 100ps
// Self-checking bench for random_tour_search_best_keeper: writes matrix entries ahead of the
// tours that use them, runs directed and random tour traffic and checks every result.
// Depends on rtsbk_pkg and the block's RTL only.

module random_tour_search_best_keeper_test;
  import rtsbk_pkg::*;

  localparam logic [1:0] OP_UNUSED       = 2'd3;
  localparam logic [2:0] ADDR_NUM_CITIES = {REG_NUM_CITIES, 2'b00};
  localparam logic [2:0] ADDR_SPARE      = {~REG_NUM_CITIES, 2'b00};
  localparam int RANDOM_ITEMS = 420;
  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [1:0]        op;
    logic [CITY_W-1:0] src_city;
    logic [CITY_W-1:0] dst_city;
    logic [EDGE_W-1:0] weight;
  } job_t;

  typedef struct packed {
    status_t           status;
    logic [CITY_W-1:0] city;
    logic [COST_W-1:0] cost;
    logic              last;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;     // from_city[4:0], to_city[9:5], edge_cost[25:10]
  logic [1:0]  in_tuser = '0;     // op[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // city[4:0], cost[26:5]
  logic [2:0]  out_tuser;         // status[2:0]
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  random_tour_search_best_keeper dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  job_t     pending_jobs[$];
  outcome_t due_results[$];
  int       fail_count = 0;
  int       job_total = 0;
  logic     calm = 1'b0;

  // Matrix entries already queued for writing
  logic written_tab [0:MAX_CITIES*MAX_CITIES-1];

  // Predictor state: matrix, tour under construction, best tour
  logic [EDGE_W-1:0]     cost_tab [0:MAX_CITIES*MAX_CITIES-1];
  logic [CITY_W-1:0]     path_store [0:1][0:PATH_SLOTS-1];
  logic [MAX_CITIES-1:0] mark_bits;
  logic                  work_sel;
  logic [CITY_W-1:0]     cur_city;
  int                    walk_len;
  logic [COST_W-1:0]     walk_cost;
  logic [COST_W-1:0]     best_cost;
  logic                  best_ok;
  int                    best_len;
  logic [NUM_W-1:0]      cities_raw;

  function automatic int cities_in_use();
    int n;
    n = int'(cities_raw);
    if (n < 2) n = 2;
    if (n > MAX_CITIES) n = MAX_CITIES;
    return n;
  endfunction

  function automatic logic [COST_W-1:0] add_capped(input logic [COST_W-1:0] a,
                                                   input logic [EDGE_W-1:0] b);
    logic [COST_W:0] sum;
    sum = {1'b0, a} + (COST_W+1)'(b);
    return (sum > COST_MAX) ? COST_MAX : sum[COST_W-1:0];
  endfunction

  // Mostly back to back, some short gaps, a few long ones; none when calm
  function automatic int pick_pause();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic int rand_weight();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 65535;
    return $urandom_range(0, 65535);
  endfunction

  task automatic push_outcome(input status_t s, input logic [CITY_W-1:0] c,
                              input logic [COST_W-1:0] k, input logic l);
    outcome_t r;
    r.status = s;
    r.city   = c;
    r.cost   = k;
    r.last   = l;
    due_results = {due_results, r};
  endtask

  task automatic begin_tour();
    mark_bits = MAX_CITIES'(1);
    cur_city  = '0;
    walk_len  = 1;
    walk_cost = '0;
    path_store[work_sel][0] = '0;
  endtask

  // Advance the predictor by one accepted transfer and queue its results
  task automatic predict_job(input job_t j);
    int n;
    int i;
    logic [COST_W-1:0] total;
    logic keep;
    n = cities_in_use();
    case (j.op)
      OP_WRITE: cost_tab[{j.src_city, j.dst_city}] = j.weight;
      OP_PROPOSE: begin
        if (walk_len >= n) begin
          // close back to city 0 whatever was proposed
          total = add_capped(walk_cost, cost_tab[{cur_city, {CITY_W{1'b0}}}]);
          keep = !best_ok || total < best_cost;
          path_store[work_sel][walk_len] = '0;
          if (keep) begin
            best_cost = total;
            best_ok   = 1'b1;
            best_len  = walk_len + 1;
            work_sel  = ~work_sel;
          end
          begin_tour();
          if (keep) push_outcome(ST_NEW_BEST, '0, total, 1'b1);
          else push_outcome(ST_NOT_BETTER, '0, total, 1'b1);
        end else if (int'(j.dst_city) >= n || mark_bits[j.dst_city]) begin
          push_outcome(ST_REJECTED, j.dst_city, walk_cost, 1'b1);
        end else begin
          walk_cost = add_capped(walk_cost, cost_tab[{cur_city, j.dst_city}]);
          mark_bits[j.dst_city] = 1'b1;
          path_store[work_sel][walk_len] = j.dst_city;
          walk_len++;
          cur_city = j.dst_city;
          push_outcome(ST_ACCEPTED, j.dst_city, walk_cost, 1'b1);
        end
      end
      OP_READ: begin
        if (!best_ok) begin
          push_outcome(ST_NO_TOUR, '0, '0, 1'b1);
        end else begin
          for (i = 0; i < best_len; i++)
            push_outcome(ST_PATH_ENTRY, path_store[~work_sel][i], best_cost,
                         i == best_len - 1);
        end
      end
      default: ;
    endcase
  endtask

  // Input driver: hold the item until its transfer, then predict and fetch the next
  job_t held_job;
  int   send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_job(held_job);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0 || pending_jobs.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_tvalid <= 1'b0;
        end else begin
          held_job = pending_jobs.pop_front();
          in_tdata <= {6'b0, held_job.weight, held_job.dst_city, held_job.src_city};
          in_tuser <= held_job.op;
          in_tvalid <= 1'b1;
          send_gap = pick_pause();
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expectation, stall at random
  int       stall_left = 0;
  int       stall_pick;
  outcome_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: status %0d city %0d cost %0d last %0b",
                   $time, out_tuser, out_tdata[4:0], out_tdata[26:5], out_tlast);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (out_tuser !== want.status || out_tdata[4:0] !== want.city ||
              out_tdata[26:5] !== want.cost || out_tlast !== want.last) begin
            $display("%0t: result mismatch: expected status %0d city %0d cost %0d last %0b",
                     $time, want.status, want.city, want.cost, want.last);
            $display("%0t:                   actual status %0d city %0d cost %0d last %0b",
                     $time, out_tuser, out_tdata[4:0], out_tdata[26:5], out_tlast);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        stall_pick = pick_pause();
        if (stall_pick > 0) stall_left = stall_pick - 1;
        out_tready <= (stall_pick == 0);
      end
    end
  end

  // Watchdog: stop when neither channel has moved for too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("random_tour_search_best_keeper_test: FAIL");
      $finish;
    end
  end

  task automatic queue_job(input logic [1:0] op, input int src, input int dst, input int w);
    job_t j;
    j.op       = op;
    j.src_city = CITY_W'(src);
    j.dst_city = CITY_W'(dst);
    j.weight   = EDGE_W'(w);
    pending_jobs = {pending_jobs, j};
    if (op == OP_WRITE) written_tab[{j.src_city, j.dst_city}] = 1'b1;
    if (op != OP_UNUSED) job_total++;
  endtask

  // Write a matrix entry with a random cost unless it already holds one
  task automatic load_edge(input logic [CITY_W-1:0] a, input logic [CITY_W-1:0] b);
    if (!written_tab[{a, b}]) queue_job(OP_WRITE, int'(a), int'(b), rand_weight());
  endtask

  // Wait until every item has gone and every result has come, plus a margin
  task automatic wait_idle();
    @(negedge clk);
    while (pending_jobs.size() != 0 || in_tvalid || due_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    while (!cfg_pready) @(negedge clk);
    rdata = cfg_prdata;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (wr && addr == ADDR_NUM_CITIES) cities_raw = data[NUM_W-1:0];
  endtask

  task automatic set_cities(input int value);
    logic [31:0] unused_rd;
    wait_idle();
    cfg_access(1'b1, ADDR_NUM_CITIES, 32'(value), unused_rd);
  endtask

  task automatic check_cities();
    logic [31:0] got;
    cfg_access(1'b0, ADDR_NUM_CITIES, '0, got);
    if (got !== 32'(cities_raw)) begin
      $display("%0t: num_cities readback mismatch: expected %0d, actual %0d",
               $time, cities_raw, got);
      fail_count++;
    end
  endtask

  // One full tour in random order with rejected proposals and other traffic mixed in
  task automatic emit_tour(input int n);
    logic [CITY_W-1:0] order [0:MAX_CITIES-1];
    logic [CITY_W-1:0] t;
    int k;
    int j;
    for (k = 0; k < n; k++) order[k] = CITY_W'(k);
    for (k = n - 1; k > 1; k--) begin
      j = $urandom_range(1, k);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (k = 1; k < n; k++) begin
      if ($urandom_range(0, 99) < 18) begin
        case ($urandom_range(0, 4))
          0: queue_job(OP_PROPOSE, $urandom_range(0, 31),
                       int'(order[$urandom_range(0, k - 1)]), rand_weight());
          1: queue_job(OP_PROPOSE, $urandom_range(0, 31),
                       (n < MAX_CITIES) ? $urandom_range(n, MAX_CITIES - 1) : 0,
                       rand_weight());
          2: queue_job(OP_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
                       rand_weight());
          3: queue_job(OP_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
                       rand_weight());
          default: queue_job(OP_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                             rand_weight());
        endcase
      end
      load_edge(order[k - 1], order[k]);
      queue_job(OP_PROPOSE, $urandom_range(0, 31), int'(order[k]), rand_weight());
    end
    // the closing proposal names any city
    load_edge(order[n - 1], '0);
    queue_job(OP_PROPOSE, $urandom_range(0, 31), $urandom_range(0, 31), rand_weight());
    if ($urandom_range(0, 99) < 25)
      queue_job(OP_READ, $urandom_range(0, 31), $urandom_range(0, 31), rand_weight());
  endtask

  initial begin
    int s;
    int raw;
    int tours;
    logic [31:0] unused_rd;

    for (s = 0; s < MAX_CITIES * MAX_CITIES; s++) begin
      cost_tab[s]    = '0;
      written_tab[s] = 1'b0;
    end
    for (s = 0; s < PATH_SLOTS; s++) begin
      path_store[0][s] = '0;
      path_store[1][s] = '0;
    end
    work_sel   = 1'b0;
    best_ok    = 1'b0;
    best_cost  = '0;
    best_len   = 0;
    cities_raw = NUM_W'(MAX_CITIES);
    begin_tour();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Readout before any tour, then an unused op
    queue_job(OP_READ, 0, 0, 0);
    queue_job(OP_UNUSED, 31, 31, 65535);

    // Load the entries that the directed tours below walk
    load_edge(CITY_W'(0), CITY_W'(1));
    load_edge(CITY_W'(1), CITY_W'(0));
    load_edge(CITY_W'(0), CITY_W'(5));
    load_edge(CITY_W'(5), CITY_W'(9));
    load_edge(CITY_W'(9), CITY_W'(17));
    load_edge(CITY_W'(17), CITY_W'(31));
    load_edge(CITY_W'(31), CITY_W'(0));
    wait_idle();
    check_cities();

    // Count below the minimum: two-city tours, rejects, ties and zero-cost tours
    set_cities(0);
    queue_job(OP_PROPOSE, 31, 0, 65535);
    queue_job(OP_PROPOSE, 0, 31, 0);
    queue_job(OP_PROPOSE, 0, 1, 0);
    queue_job(OP_PROPOSE, 0, 17, 0);
    queue_job(OP_READ, 0, 0, 0);
    queue_job(OP_PROPOSE, 0, 1, 0);
    queue_job(OP_PROPOSE, 0, 0, 0);
    queue_job(OP_WRITE, 0, 1, 0);
    queue_job(OP_WRITE, 1, 0, 0);
    queue_job(OP_PROPOSE, 0, 1, 0);
    queue_job(OP_PROPOSE, 0, 31, 0);
    queue_job(OP_PROPOSE, 0, 1, 0);
    queue_job(OP_PROPOSE, 0, 2, 0);
    queue_job(OP_READ, 0, 0, 0);

    // Count above the maximum, then lower it mid-tour so the next proposal closes
    set_cities(63);
    queue_job(OP_PROPOSE, 0, 5, 0);
    queue_job(OP_PROPOSE, 0, 9, 0);
    queue_job(OP_PROPOSE, 0, 17, 0);
    queue_job(OP_PROPOSE, 0, 31, 0);
    set_cities(3);
    queue_job(OP_PROPOSE, 0, 12, 0);
    queue_job(OP_READ, 0, 0, 0);
    wait_idle();
    cfg_access(1'b1, ADDR_SPARE, 32'd5, unused_rd);
    check_cities();

    // Random phases: mostly small city counts, now and then the full size
    job_total = 0;
    while (job_total < RANDOM_ITEMS) begin
      case ($urandom_range(0, 11))
        0: raw = 32;
        1: raw = 63;
        2: raw = $urandom_range(0, 2);
        default: raw = $urandom_range(3, 8);
      endcase
      set_cities(raw);
      calm = ($urandom_range(0, 3) == 0);
      tours = (cities_in_use() > 16) ? 1 : $urandom_range(3, 8);
      repeat (tours) emit_tour(cities_in_use());
      queue_job(OP_READ, $urandom_range(0, 31), $urandom_range(0, 31), rand_weight());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("random_tour_search_best_keeper_test: PASS");
    end else begin
      $display("random_tour_search_best_keeper_test: FAIL");
    end
    $finish;
  end

endmodule
